// ===== sv/glitch_filtered_frequency_meter_defines.svh =====
// Assertion macros used by the checker of the frequency meter.
`ifndef GLITCH_FILTERED_FREQUENCY_METER_DEFINES_SVH
`define GLITCH_FILTERED_FREQUENCY_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFFM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFFM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/gffm_pkg.sv =====
package gffm_pkg;

    localparam int TIME_BITS_DEF   = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TIME_FIELD_BITS = 32;
    localparam int FREQ_BITS       = 36;
    localparam int COUNT_BITS      = 32;
    localparam int MHZ_BITS        = 20;
    localparam int ONE_MHZ         = 1000000;
    localparam int THRESH_BITS     = 31;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_W          = 17;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [GAIN_W-1:0]         GAIN_ONE  = GAIN_W'(1) << GAIN_BITS;
    localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GLITCH_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTHING_GAIN   = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic                       sample_level;
        logic [TIME_FIELD_BITS-1:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic                 filtered_level;
        logic                 measured;
        logic [FREQ_BITS-1:0] freq_hz;
        logic [FREQ_BITS-1:0] max_freq_hz;
        logic [FREQ_BITS-1:0] freq_error_hz;
        logic [FREQ_BITS-1:0] freq_smoothed_hz;
        logic                 divide_flag;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVF,
        S_MULD,
        S_MULN,
        S_DIVM,
        S_ERR,
        S_SCMP,
        S_SNEG,
        S_SMUL,
        S_SUPD,
        S_DONE
    } t_state;

endpackage

// ===== sv/glitch_filtered_frequency_meter.sv =====
// Glitch-filtered reciprocal-period frequency meter.
// The input channel carries one pin sample with its microsecond timestamp per request;
// the output channel returns exactly one result per sample, in order. Both channels
// use valid and stall. The configuration channel (valid/ready, always ready) writes
// the glitch threshold (index 0) and the smoothing gain (index 1), to be written only
// while the block idles; the block itself does not enforce this. A sample that is not an
// accepted rising edge goes straight into a free output register and the block stays ready.
// An accepted rising edge runs a shared add/subtract unit under a sequencer: a
// restoring divide for the reciprocal (20+FRAC_BITS steps), two shift-add products
// (32 steps each), a divide for the bound (52+FRAC_BITS steps), one step for the
// error and, for periods of one second or more, 19 to 20 steps of smoothing.
// A zero period skips the arithmetic; fewer than two samples in the period skip the products
// and the bound divide. Any result that finds the output register full waits in S_DONE.
// The input is stalled while a measurement runs and while a finished result waits
// for a full output register; a stalled output holds its result unchanged.
// Reset is synchronous and active low: levels, timestamps, sample count and result values
// clear to zero, the threshold to zero and the gain to one, and no result is pending.
module glitch_filtered_frequency_meter #(
    parameter int TIME_BITS = gffm_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = gffm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  gffm_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output gffm_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gffm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [gffm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import gffm_pkg::*;

    localparam int RB   = MHZ_BITS + FRAC_BITS;
    localparam int DB   = TIME_BITS + COUNT_BITS;
    localparam int NB   = RB + COUNT_BITS;
    localparam int QB   = RB + 1;
    localparam int AW   = (DB + 1 > NB) ? DB + 1 : NB;
    localparam int CW   = $clog2(AW + 1);
    localparam int CMPW = (TIME_BITS > THRESH_BITS) ? TIME_BITS : THRESH_BITS;

    localparam logic [RB-1:0]   RECIP   = RB'(ONE_MHZ) << FRAC_BITS;
    localparam logic [CMPW-1:0] ONE_SEC = CMPW'(ONE_MHZ);

    t_state                 r_state, n_state;
    logic                   r_raw, n_raw;
    logic                   r_lvl, n_lvl;
    logic [TIME_BITS-1:0]   r_last_chg, n_last_chg;
    logic [TIME_BITS-1:0]   r_last_rise, n_last_rise;
    logic [TIME_BITS-1:0]   r_period, n_period;
    logic [COUNT_BITS-1:0]  r_samples, n_samples;
    logic [COUNT_BITS-1:0]  r_n, n_n;
    logic [COUNT_BITS-1:0]  r_mplr, n_mplr;
    logic [RB-1:0]          r_freq, n_freq;
    logic [RB-1:0]          r_max, n_max;
    logic [RB-1:0]          r_err, n_err;
    logic [RB-1:0]          r_smooth, n_smooth;
    logic [AW-1:0]          r_acc, n_acc;
    logic [AW-1:0]          r_opa, n_opa;
    logic [AW-1:0]          r_opb, n_opb;
    logic [QB-1:0]          r_quo, n_quo;
    logic                   r_ovf, n_ovf;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_meas, n_meas;
    logic                   r_flag, n_flag;
    logic                   r_up, n_up;
    logic                   r_smooth_en, n_smooth_en;
    logic [THRESH_BITS-1:0] r_thresh, n_thresh;
    logic [GAIN_W-1:0]      r_gain, n_gain;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic [TIME_BITS-1:0]   w_now;
    logic [TIME_BITS-1:0]   w_elapsed;
    logic [TIME_BITS-1:0]   w_period_now;
    logic                   w_change;
    logic                   w_rise;
    logic [AW-1:0]          w_alu_x;
    logic [AW-1:0]          w_alu_y;
    logic                   w_alu_sub;
    logic                   w_alu_cin;
    logic [AW:0]            w_alu_sum;
    logic                   w_carry;
    logic [AW-1:0]          w_div_x;
    logic [AW-1:0]          w_rem_next;
    logic [AW-1:0]          w_mac_next;
    logic [QB-1:0]          w_quo_next;
    logic                   w_ovf_next;
    logic [GAIN_W-1:0]      w_gain_sat;
    logic [AW-1:0]          w_prod_q;
    logic                   w_prod_rnd;
    logic                   w_last;
    logic                   w_out_free;
    logic                   w_load;

    assign w_now        = TIME_BITS'(i_in.time_us);
    assign w_elapsed    = w_now - r_last_chg;
    assign w_period_now = w_now - r_last_rise;
    assign w_change     = (i_in.sample_level != r_raw)
                          && (CMPW'(w_elapsed) > CMPW'(r_thresh));
    assign w_rise       = w_change && !r_lvl && i_in.sample_level;

    assign w_div_x    = {r_acc[AW-2:0], r_opa[AW-1]};
    assign w_gain_sat = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign w_prod_q   = r_acc >> GAIN_BITS;
    assign w_prod_rnd = |r_acc[GAIN_BITS-1:0];

    always_comb begin
        w_alu_x   = '0;
        w_alu_y   = '0;
        w_alu_sub = 1'b0;
        w_alu_cin = 1'b0;
        case (r_state)
            S_DIVF, S_DIVM: begin
                w_alu_x   = w_div_x;
                w_alu_y   = r_opb;
                w_alu_sub = 1'b1;
                w_alu_cin = 1'b1;
            end
            S_MULD, S_MULN, S_SMUL: begin
                w_alu_x = r_acc;
                w_alu_y = r_opa;
            end
            S_ERR: begin
                w_alu_x   = AW'(r_max);
                w_alu_y   = AW'(r_freq);
                w_alu_sub = 1'b1;
                w_alu_cin = 1'b1;
            end
            S_SCMP: begin
                w_alu_x   = AW'(r_freq);
                w_alu_y   = AW'(r_smooth);
                w_alu_sub = 1'b1;
                w_alu_cin = 1'b1;
            end
            S_SNEG: begin
                w_alu_x   = AW'(r_smooth);
                w_alu_y   = AW'(r_freq);
                w_alu_sub = 1'b1;
                w_alu_cin = 1'b1;
            end
            S_SUPD: begin
                w_alu_x   = AW'(r_smooth);
                w_alu_y   = w_prod_q;
                w_alu_sub = !r_up;
                w_alu_cin = !r_up && !w_prod_rnd;
            end
            default: begin
            end
        endcase
    end

    assign w_alu_sum  = {1'b0, w_alu_x} + {1'b0, (w_alu_sub ? ~w_alu_y : w_alu_y)}
                        + {{AW{1'b0}}, w_alu_cin};
    assign w_carry    = w_alu_sum[AW];
    assign w_rem_next = w_carry ? w_alu_sum[AW-1:0] : w_div_x;
    assign w_mac_next = r_mplr[0] ? w_alu_sum[AW-1:0] : r_acc;
    assign w_quo_next = {r_quo[QB-2:0], w_carry};
    assign w_ovf_next = r_ovf | r_quo[QB-1];
    assign w_last     = (r_cnt == CW'(1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_raw       = r_raw;
        n_lvl       = r_lvl;
        n_last_chg  = r_last_chg;
        n_last_rise = r_last_rise;
        n_period    = r_period;
        n_samples   = r_samples;
        n_n         = r_n;
        n_mplr      = r_mplr;
        n_freq      = r_freq;
        n_max       = r_max;
        n_err       = r_err;
        n_smooth    = r_smooth;
        n_acc       = r_acc;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_quo       = r_quo;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_meas      = r_meas;
        n_flag      = r_flag;
        n_up        = r_up;
        n_smooth_en = r_smooth_en;
        n_thresh    = r_thresh;
        n_gain      = r_gain;
        w_load      = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GLITCH_THRESHOLD: n_thresh = i_cfg_data[THRESH_BITS-1:0];
                CFG_SMOOTHING_GAIN:   n_gain   = i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw = i_in.sample_level;
                    if (i_in.sample_level != r_raw) begin
                        n_last_chg = w_now;
                    end
                    if (w_change) begin
                        n_lvl = i_in.sample_level;
                    end
                    if (r_samples != COUNT_MAX) begin
                        n_samples = r_samples + 1'b1;
                    end
                    n_meas = w_rise;
                    n_flag = 1'b0;
                    if (w_rise) begin
                        n_samples   = COUNT_BITS'(1);
                        n_last_rise = w_now;
                        n_period    = w_period_now;
                        n_n         = r_samples;
                        n_smooth_en = (CMPW'(w_period_now) >= ONE_SEC);
                        if (w_period_now == '0) begin
                            n_freq  = RECIP;
                            n_max   = RECIP;
                            n_err   = '0;
                            n_flag  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_flag  = (r_samples <= COUNT_BITS'(1));
                            n_acc   = '0;
                            n_opa   = AW'(RECIP) << (AW - RB);
                            n_opb   = AW'(w_period_now);
                            n_quo   = '0;
                            n_ovf   = 1'b0;
                            n_cnt   = CW'(RB);
                            n_state = S_DIVF;
                        end
                    end else if (w_out_free) begin
                        w_load = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIVF: begin
                n_acc = w_rem_next;
                n_opa = r_opa << 1;
                n_quo = w_quo_next;
                n_ovf = w_ovf_next;
                n_cnt = r_cnt - 1'b1;
                if (w_last) begin
                    n_freq = w_quo_next[RB-1:0];
                    if (r_flag) begin
                        n_max   = RECIP;
                        n_state = S_ERR;
                    end else begin
                        n_acc   = '0;
                        n_opa   = AW'(r_period);
                        n_mplr  = r_n - 1'b1;
                        n_cnt   = CW'(COUNT_BITS);
                        n_state = S_MULD;
                    end
                end
            end
            S_MULD: begin
                n_acc  = w_mac_next;
                n_opa  = r_opa << 1;
                n_mplr = r_mplr >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_opb   = w_mac_next;
                    n_acc   = '0;
                    n_opa   = AW'(RECIP);
                    n_mplr  = r_n;
                    n_cnt   = CW'(COUNT_BITS);
                    n_state = S_MULN;
                end
            end
            S_MULN: begin
                n_acc  = w_mac_next;
                n_opa  = r_opa << 1;
                n_mplr = r_mplr >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_opa   = w_mac_next << (AW - NB);
                    n_acc   = '0;
                    n_quo   = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = CW'(NB);
                    n_state = S_DIVM;
                end
            end
            S_DIVM: begin
                n_acc = w_rem_next;
                n_opa = r_opa << 1;
                n_quo = w_quo_next;
                n_ovf = w_ovf_next;
                n_cnt = r_cnt - 1'b1;
                if (w_last) begin
                    if (w_ovf_next || (w_quo_next > QB'(RECIP))) begin
                        n_max = RECIP;
                    end else begin
                        n_max = w_quo_next[RB-1:0];
                    end
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_err   = w_carry ? w_alu_sum[RB-1:0] : '0;
                n_state = r_smooth_en ? S_SCMP : S_DONE;
            end
            S_SCMP, S_SNEG: begin
                if (w_carry || (r_state == S_SNEG)) begin
                    n_up    = (r_state == S_SCMP);
                    n_acc   = '0;
                    n_opa   = w_alu_sum[AW-1:0];
                    n_mplr  = COUNT_BITS'(w_gain_sat);
                    n_cnt   = CW'(GAIN_W);
                    n_state = S_SMUL;
                end else begin
                    n_state = S_SNEG;
                end
            end
            S_SMUL: begin
                n_acc  = w_mac_next;
                n_opa  = r_opa << 1;
                n_mplr = r_mplr >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_state = S_SUPD;
                end
            end
            S_SUPD: begin
                n_smooth = w_alu_sum[RB-1:0];
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.filtered_level   = n_lvl;
        n_out.measured         = n_meas;
        n_out.freq_hz          = FREQ_BITS'(n_freq);
        n_out.max_freq_hz      = FREQ_BITS'(n_max);
        n_out.freq_error_hz    = FREQ_BITS'(n_err);
        n_out.freq_smoothed_hz = FREQ_BITS'(n_smooth);
        n_out.divide_flag      = n_flag;

        n_out_valid = (r_out_valid && i_out_stall) || w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_raw       <= 1'b0;
            r_lvl       <= 1'b0;
            r_last_chg  <= '0;
            r_last_rise <= '0;
            r_samples   <= '0;
            r_freq      <= '0;
            r_max       <= '0;
            r_err       <= '0;
            r_smooth    <= '0;
            r_thresh    <= '0;
            r_gain      <= GAIN_ONE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_raw       <= n_raw;
            r_lvl       <= n_lvl;
            r_last_chg  <= n_last_chg;
            r_last_rise <= n_last_rise;
            r_samples   <= n_samples;
            r_freq      <= n_freq;
            r_max       <= n_max;
            r_err       <= n_err;
            r_smooth    <= n_smooth;
            r_thresh    <= n_thresh;
            r_gain      <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period    <= n_period;
        r_n         <= n_n;
        r_mplr      <= n_mplr;
        r_acc       <= n_acc;
        r_opa       <= n_opa;
        r_opb       <= n_opb;
        r_quo       <= n_quo;
        r_ovf       <= n_ovf;
        r_cnt       <= n_cnt;
        r_meas      <= n_meas;
        r_flag      <= n_flag;
        r_up        <= n_up;
        r_smooth_en <= n_smooth_en;
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/gffm_checker.sv =====
`include "glitch_filtered_frequency_meter_defines.svh"

module gffm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gffm_pkg::t_out_item o_out
);
    import gffm_pkg::*;

    `GFFM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")
    `GFFM_ASSERT_SAME(a_rise_level, i_clk, i_rst_n, o_out_valid && o_out.measured, o_out.filtered_level, "measurement without high level")
    `GFFM_ASSERT_SAME(a_flag_meas, i_clk, i_rst_n, o_out_valid && o_out.divide_flag, o_out.measured, "divide flag outside a measurement")
    `GFFM_ASSERT_SAME(a_error_sum, i_clk, i_rst_n, o_out_valid, o_out.freq_error_hz == o_out.max_freq_hz - o_out.freq_hz, "error is not bound minus frequency")

endmodule

bind glitch_filtered_frequency_meter gffm_checker u_gffm_checker (.*);

// ===== sim/glitch_filtered_frequency_meter_test.sv =====
`timescale 1ns / 1ps

module glitch_filtered_frequency_meter_test;
    import gffm_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   HOLD_AT        = 200;
    localparam int                   HOLD_CYCLES    = 400;
    localparam logic [FREQ_BITS-1:0] RECIP_NUM      = FREQ_BITS'(ONE_MHZ) << FRAC_BITS_DEF;

    typedef enum logic [1:0] {
        RCV_FLOW,
        RCV_RANDOM,
        RCV_PATTERN
    } t_rcv_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    t_in_item                  i_in = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_item                 o_out;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_GLITCH_THRESHOLD;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    glitch_filtered_frequency_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the meter state and its configuration.
    logic                       mtr_raw = 1'b0;
    logic                       mtr_acc = 1'b0;
    logic [TIME_FIELD_BITS-1:0] mtr_last_change = '0;
    logic [TIME_FIELD_BITS-1:0] mtr_last_rise = '0;
    logic [COUNT_BITS-1:0]      mtr_count = '0;
    logic [FREQ_BITS-1:0]       mtr_freq = '0;
    logic [FREQ_BITS-1:0]       mtr_max = '0;
    logic [FREQ_BITS-1:0]       mtr_err = '0;
    logic [FREQ_BITS-1:0]       mtr_smooth = '0;
    logic [THRESH_BITS-1:0]     mtr_thr = '0;
    logic [GAIN_W-1:0]          mtr_gain = GAIN_ONE;

    t_in_item                   sample_q[$];
    t_out_item                  meter_result_q[$];
    int unsigned                samples_queued = 0;
    int unsigned                results_checked = 0;
    int unsigned                results_seen = 0;
    int unsigned                errors = 0;
    logic [TIME_FIELD_BITS-1:0] stim_t = '0;

    task automatic meter_step(input t_in_item s, output t_out_item r);
        logic [TIME_FIELD_BITS-1:0] elapsed;
        logic [TIME_FIELD_BITS-1:0] period;
        logic [127:0]               num;
        logic [127:0]               den;
        logic [127:0]               quo;
        logic [63:0]                g;
        logic [63:0]                prod;
        logic                       rose;
        logic                       flag;
        rose = 1'b0;
        flag = 1'b0;
        if (s.sample_level != mtr_raw) begin
            elapsed = s.time_us - mtr_last_change;
            if (elapsed > TIME_FIELD_BITS'(mtr_thr)) begin
                if (!mtr_acc && s.sample_level) begin
                    mtr_acc = 1'b1;
                    rose = 1'b1;
                    period = s.time_us - mtr_last_rise;
                    if (period == 0) begin
                        mtr_freq = RECIP_NUM;
                        flag = 1'b1;
                    end else begin
                        mtr_freq = RECIP_NUM / period;
                    end
                    if (period == 0 || mtr_count <= 1) begin
                        mtr_max = RECIP_NUM;
                        flag = 1'b1;
                    end else begin
                        num = 128'(RECIP_NUM) * 128'(mtr_count);
                        den = 128'(period) * 128'(mtr_count - 1);
                        quo = num / den;
                        mtr_max = (quo > 128'(RECIP_NUM)) ? RECIP_NUM : quo[FREQ_BITS-1:0];
                    end
                    mtr_err = (mtr_max >= mtr_freq) ? mtr_max - mtr_freq : '0;
                    if (period >= TIME_FIELD_BITS'(ONE_MHZ)) begin
                        g = (mtr_gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(mtr_gain);
                        if (mtr_freq >= mtr_smooth) begin
                            prod = 64'(mtr_freq - mtr_smooth) * g;
                            mtr_smooth = mtr_smooth + FREQ_BITS'(prod >> GAIN_BITS);
                        end else begin
                            prod = 64'(mtr_smooth - mtr_freq) * g;
                            mtr_smooth = mtr_smooth
                                - FREQ_BITS'((prod + 64'(GAIN_ONE) - 64'd1) >> GAIN_BITS);
                        end
                    end
                    mtr_count = '0;
                    mtr_last_rise = s.time_us;
                end else if (mtr_acc && !s.sample_level) begin
                    mtr_acc = 1'b0;
                end
            end
            mtr_last_change = s.time_us;
        end
        mtr_raw = s.sample_level;
        if (mtr_count != COUNT_MAX) begin
            mtr_count = mtr_count + 1;
        end
        r.filtered_level   = mtr_acc;
        r.measured         = rose;
        r.freq_hz          = mtr_freq;
        r.max_freq_hz      = mtr_max;
        r.freq_error_hz    = mtr_err;
        r.freq_smoothed_hz = mtr_smooth;
        r.divide_flag      = flag;
    endtask

    task automatic check_field(input string name, input logic [FREQ_BITS-1:0] exp_v,
                               input logic [FREQ_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name,
                     exp_v, act_v);
        end
    endtask

    // Monitor: predicts on every accepted sample and checks every accepted result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (meter_result_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, o_out);
                end else begin
                    want = meter_result_q.pop_front();
                    results_checked++;
                    check_field("filtered_level", FREQ_BITS'(want.filtered_level),
                                FREQ_BITS'(o_out.filtered_level));
                    check_field("measured", FREQ_BITS'(want.measured),
                                FREQ_BITS'(o_out.measured));
                    check_field("freq_hz", want.freq_hz, o_out.freq_hz);
                    check_field("max_freq_hz", want.max_freq_hz, o_out.max_freq_hz);
                    check_field("freq_error_hz", want.freq_error_hz, o_out.freq_error_hz);
                    check_field("freq_smoothed_hz", want.freq_smoothed_hz,
                                o_out.freq_smoothed_hz);
                    check_field("divide_flag", FREQ_BITS'(want.divide_flag),
                                FREQ_BITS'(o_out.divide_flag));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                meter_step(i_in, want);
                meter_result_q.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GLITCH_THRESHOLD) begin
                    mtr_thr = i_cfg_data[THRESH_BITS-1:0];
                end else if (i_cfg_index == CFG_SMOOTHING_GAIN) begin
                    mtr_gain = i_cfg_data[GAIN_W-1:0];
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                i_in <= sample_q.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in changing patterns, and once holds off long enough to fill the block.
    t_rcv_mode   stall_mode = RCV_FLOW;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic [7:0]  rcv_tick = '0;

    always @(posedge i_clk) begin
        rcv_tick <= rcv_tick + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_rcv_mode'($urandom_range(0, 2));
                mode_left <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RCV_FLOW: begin
                    i_out_stall <= 1'b0;
                end
                RCV_RANDOM: begin
                    i_out_stall <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    i_out_stall <= (rcv_tick[2:0] < 3'd3);
                end
            endcase
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL glitch_filtered_frequency_meter");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_sample(input logic lvl, input logic [TIME_FIELD_BITS-1:0] t);
        t_in_item s;
        s.sample_level = lvl;
        s.time_us = t;
        sample_q.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [THRESH_BITS-1:0] thr, input logic [GAIN_W-1:0] gain);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_GLITCH_THRESHOLD, {junk[31], thr});
        write_reg(CFG_SMOOTHING_GAIN, {junk[14:0], gain});
    endtask

    task automatic wait_drained();
        while (results_checked != samples_queued) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // A square wave with k samples per half period, with occasional short glitches.
    task automatic gen_wave(input logic [THRESH_BITS-1:0] thr);
        int unsigned                k;
        int unsigned                cycles;
        int unsigned                sel;
        logic [TIME_FIELD_BITS-1:0] step;
        logic                       lvl;
        k = $urandom_range(1, 4);
        cycles = $urandom_range(2, 6);
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            step = TIME_FIELD_BITS'(thr) / k + $urandom_range(1, 400);
        end else if (sel < 9) begin
            step = TIME_FIELD_BITS'(thr) / k + ONE_MHZ / (2 * k) + $urandom_range(0, 400000);
        end else begin
            step = $urandom_range(0, 3);
        end
        repeat (cycles) begin
            for (int h = 0; h < 2; h++) begin
                lvl = (h == 0);
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        stim_t = stim_t + $urandom_range(0, 3);
                        add_sample(!lvl, stim_t);
                    end
                    stim_t = stim_t + step;
                    add_sample(lvl, stim_t);
                end
            end
        end
    endtask

    task automatic random_phase(input logic [THRESH_BITS-1:0] thr,
                                input logic [GAIN_W-1:0] gain, input int unsigned n_items);
        int unsigned start;
        set_config(thr, gain);
        start = samples_queued;
        while (samples_queued - start < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                gen_wave(thr);
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    stim_t = $urandom;
                end
                repeat ($urandom_range(1, 5)) add_sample(1'($urandom_range(0, 1)), $urandom);
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [TIME_FIELD_BITS-1:0] t0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first rise with no samples, zero period, period of one,
        // time wrap, rejected changes at zero threshold and long periods.
        add_sample(1'b1, 32'd7);
        add_sample(1'b1, 32'd8);
        add_sample(1'b0, 32'd9);
        add_sample(1'b0, 32'd5);
        add_sample(1'b1, 32'd7);
        add_sample(1'b0, 32'd100);
        add_sample(1'b1, 32'd1000107);
        add_sample(1'b0, 32'd1000200);
        add_sample(1'b1, 32'd1000108);
        add_sample(1'b0, 32'hFFFF_FF00);
        add_sample(1'b1, 32'hFFFF_FFF0);
        add_sample(1'b0, 32'h0000_0005);
        add_sample(1'b1, 32'h0000_0020);
        add_sample(1'b0, 32'h0000_0020);
        add_sample(1'b1, 32'h0000_0020);
        add_sample(1'b0, 32'hFFFF_FFFF);
        t0 = 32'd2000032;
        add_sample(1'b1, t0);
        wait_drained();

        // Glitches around a nonzero threshold and smoothing toward a lower frequency.
        set_config(31'd50, 17'h08000);
        add_sample(1'b0, t0 + 32'd10);
        add_sample(1'b1, t0 + 32'd20);
        add_sample(1'b0, t0 + 32'd100);
        add_sample(1'b1, t0 + 32'd3000000);
        add_sample(1'b0, t0 + 32'd3000050);
        add_sample(1'b1, t0 + 32'd3000101);
        wait_drained();

        // Largest threshold and a gain above one.
        set_config('1, '1);
        t0 = t0 + 32'd3000101 + 32'h7FFF_FFFF;
        add_sample(1'b0, t0);
        t0 = t0 + 32'h8000_0000;
        add_sample(1'b1, t0);
        t0 = t0 + 32'h8000_0000;
        add_sample(1'b0, t0);
        t0 = t0 + 32'hFFFF_FFFF;
        add_sample(1'b1, t0);
        wait_drained();

        stim_t = t0;
        random_phase('0, GAIN_ONE, 100);
        random_phase(THRESH_BITS'($urandom_range(1, 200)), GAIN_W'($urandom_range(1, 65535)), 100);
        random_phase('0, '0, 100);
        random_phase(THRESH_BITS'($urandom), GAIN_W'($urandom_range(65537, 131071)), 100);
        random_phase('1, GAIN_ONE, 100);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && meter_result_q.size() == 0) begin
            $display("PASS glitch_filtered_frequency_meter");
        end else begin
            $display("FAIL glitch_filtered_frequency_meter");
        end
        $finish;
    end

endmodule
